// ===== sv/dts_pkg.sv =====
package dts_pkg;

   // Event codes carried in req_tuser.
   typedef enum logic [1:0] {
      MODE_TURN = 2'd0,
      MODE_NEXT = 2'd1,
      MODE_SAVE = 2'd2,
      MODE_LOAD = 2'd3
   } mode_type;

   // Selected field codes.
   typedef enum logic [2:0] {
      FLD_YEAR   = 3'd0,
      FLD_MONTH  = 3'd1,
      FLD_DAY    = 3'd2,
      FLD_HOUR   = 3'd3,
      FLD_MINUTE = 3'd4
   } field_type;

   // Configuration register indexes.
   localparam logic CSR_MIN_YEAR = 1'b0;
   localparam logic CSR_MAX_YEAR = 1'b1;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   localparam logic [11:0] MIN_YEAR_RESET = 12'd2023;
   localparam logic [11:0] MAX_YEAR_RESET = 12'd2099;
   localparam logic [11:0] YEAR_RESET     = 12'd2024;

   // floor(v * RECIP_25 / 2**15) equals floor(v / 25) for v below 4681.
   localparam logic [13:0] RECIP_25 = 14'd1311;
   // floor(s * RECIP_7 / 2**16) equals floor(s / 7) for s below 13107.
   localparam logic [13:0] RECIP_7  = 14'd9363;

   localparam logic [5:0] HOURS_PER_DAY    = 6'd24;
   localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
   localparam logic [5:0] MONTHS_PER_YEAR  = 6'd12;

   function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month)
         4'd2:                      days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
         default:                   days = 5'd31;
      endcase
      return days;
   endfunction

   // Month offsets of the Sakamoto weekday method, month one based.
   function automatic logic [2:0] month_offset(input logic [3:0] month);
      logic [2:0] offs;
      case (month)
         4'd2:    offs = 3'd3;
         4'd3:    offs = 3'd2;
         4'd4:    offs = 3'd5;
         4'd5:    offs = 3'd0;
         4'd6:    offs = 3'd3;
         4'd7:    offs = 3'd5;
         4'd8:    offs = 3'd1;
         4'd9:    offs = 3'd4;
         4'd10:   offs = 3'd6;
         4'd11:   offs = 3'd2;
         4'd12:   offs = 3'd4;
         default: offs = 3'd0;
      endcase
      return offs;
   endfunction

endpackage

// ===== sv/date_time_setter.sv =====
// Next, load and a zero-detent turn go from S_EXEC to S_FINISH, which registers the result;
// other turns and save run S_DIV_A to S_DIV_C on the shared multiplier, then a year turn
// S_CLAMP, another turn up to three wrap passes on the shared add and compare unit and
// S_CLAMP, save S_WD_SUM to S_WD_FIN. One item at a time; the next can be taken from the
// cycle after a result is registered. Reset (synchronous, active high): 1 January 2024 00:00
// with the year field selected, min_year 2023, max_year 2099 and the output register empty.
module date_time_setter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // detents[5:0], clock_ok[6], clock_year[18:7], clock_month[22:19],
   // clock_day[28:23], clock_hour[34:29], clock_minute[41:35], zero fill above
   input  logic [dts_pkg::REQ_DATA_W-1:0]      req_tdata,
   // mode[1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // cur_year[11:0], cur_month[15:12], cur_day[20:16], cur_hour[25:21],
   // cur_minute[31:26], selected_field[34:32], weekday[37:35], zero fill above
   output logic [dts_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // commit[0]
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [11:0]                         csr_data
);

   localparam int RSP_W = dts_pkg::RSP_DATA_W;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_EXEC   = 11'b000_0000_0010,
      S_DIV_A  = 11'b000_0000_0100,
      S_DIV_B  = 11'b000_0000_1000,
      S_DIV_C  = 11'b000_0001_0000,
      S_WRAP   = 11'b000_0010_0000,
      S_CLAMP  = 11'b000_0100_0000,
      S_WD_SUM = 11'b000_1000_0000,
      S_WD_MUL = 11'b001_0000_0000,
      S_WD_FIN = 11'b010_0000_0000,
      S_FINISH = 11'b100_0000_0000
   } state_type;

   state_type           state_ff, state_in;
   dts_pkg::mode_type   mode_ff, mode_in;
   logic [41:0]         data_ff, data_in;
   logic [11:0]         min_year_ff, min_year_in;
   logic [11:0]         max_year_ff, max_year_in;
   logic [11:0]         year_ff, year_in;
   logic [3:0]          month_ff, month_in;
   logic [4:0]          day_ff, day_in;
   logic [4:0]          hour_ff, hour_in;
   logic [5:0]          minute_ff, minute_in;
   dts_pkg::field_type  field_ff, field_in;
   logic [11:0]         yop_ff, yop_in;
   logic                yneg_ff, yneg_in;
   logic signed [7:0]   acc_ff, acc_in;
   logic [5:0]          mod_ff, mod_in;
   logic [26:0]         prod_ff, prod_in;
   logic [5:0]          q100_ff, q100_in;
   logic [3:0]          q400_ff, q400_in;
   logic                r25_ff, r25_in;
   logic                leap_ff, leap_in;
   logic [12:0]         sum_ff, sum_in;
   logic [2:0]          wd_ff, wd_in;
   logic                commit_ff, commit_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                rsp_commit_ff, rsp_commit_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Fields of the latched request.
   logic signed [5:0]   det;
   logic                clk_ok;
   logic [11:0]         clk_year;
   logic [3:0]          clk_month;
   logic [5:0]          clk_day;
   logic [5:0]          clk_hour;
   logic [6:0]          clk_minute;
   logic                load_good;

   // Shared multiplier and shared add and compare unit.
   logic [12:0]         mul_a;
   logic [13:0]         mul_k;
   logic signed [7:0]   mod_s;
   logic signed [7:0]   wrap_sum;
   logic                acc_low;
   logic                acc_high;

   logic signed [13:0]  yr_sum;
   logic [11:0]         yr_clamped;
   logic signed [7:0]   det_ext;
   logic signed [7:0]   acc_base;
   logic [5:0]          q100_now;
   logic [3:0]          q400_now;
   logic                r25b_now;
   logic                leap_now;
   logic [4:0]          dim_now;
   logic [9:0]          q7_now;
   logic [12:0]         wd_full;

   assign det        = signed'(data_ff[5:0]);
   assign clk_ok     = data_ff[6];
   assign clk_year   = data_ff[18:7];
   assign clk_month  = data_ff[22:19];
   assign clk_day    = data_ff[28:23];
   assign clk_hour   = data_ff[34:29];
   assign clk_minute = data_ff[41:35];
   assign load_good  = clk_ok && (clk_year >= min_year_ff) && (clk_month <= 4'd11);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_commit_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      mul_a = '0;
      mul_k = '0;
      unique case (state_ff)
         S_DIV_A: begin
            mul_a = {3'b000, yop_ff[11:2]};
            mul_k = dts_pkg::RECIP_25;
         end
         S_DIV_B: begin
            mul_a = {5'b00000, yop_ff[11:4]};
            mul_k = dts_pkg::RECIP_25;
         end
         S_WD_MUL: begin
            mul_a = sum_ff;
            mul_k = dts_pkg::RECIP_7;
         end
         default: begin
            mul_a = '0;
            mul_k = '0;
         end
      endcase
   end

   assign prod_in = {14'd0, mul_a} * {13'd0, mul_k};

   assign mod_s    = signed'({2'b00, mod_ff});
   assign acc_low  = acc_ff < 8'sd0;
   assign acc_high = acc_ff >= mod_s;
   assign wrap_sum = acc_low ? (acc_ff + mod_s) : (acc_ff - mod_s);

   assign det_ext    = {{2{det[5]}}, det};
   assign yr_sum     = signed'({2'b00, year_ff}) + signed'({{8{det[5]}}, det});
   assign yr_clamped = (yr_sum > signed'({2'b00, max_year_ff})) ? max_year_ff :
                       (yr_sum < signed'({2'b00, min_year_ff})) ?
                       ((min_year_ff > max_year_ff) ? max_year_ff : min_year_ff) :
                       yr_sum[11:0];

   always_comb begin
      case (field_ff)
         dts_pkg::FLD_MONTH:  acc_base = signed'({4'b0000, month_ff}) - 8'sd1;
         dts_pkg::FLD_DAY:    acc_base = signed'({3'b000, day_ff}) - 8'sd1;
         dts_pkg::FLD_HOUR:   acc_base = signed'({3'b000, hour_ff});
         dts_pkg::FLD_MINUTE: acc_base = signed'({2'b00, minute_ff});
         default:             acc_base = 8'sd0;
      endcase
   end

   assign q100_now = prod_ff[20:15];
   assign q400_now = prod_ff[18:15];
   assign r25b_now = (8'(q400_now * 8'd25) == yop_ff[11:4]);
   assign leap_now = (yop_ff[1:0] == 2'b00) && (!r25_ff || ((yop_ff[3:0] == 4'd0) && r25b_now));
   assign dim_now  = dts_pkg::days_in_month(month_ff, leap_now);
   assign q7_now   = prod_ff[25:16];
   assign wd_full  = sum_ff - 13'(q7_now * 13'd7);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      data_in       = data_ff;
      min_year_in   = min_year_ff;
      max_year_in   = max_year_ff;
      year_in       = year_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      field_in      = field_ff;
      yop_in        = yop_ff;
      yneg_in       = yneg_ff;
      acc_in        = acc_ff;
      mod_in        = mod_ff;
      q100_in       = q100_ff;
      q400_in       = q400_ff;
      r25_in        = r25_ff;
      leap_in       = leap_ff;
      sum_in        = sum_ff;
      wd_in         = wd_ff;
      commit_in     = commit_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_commit_in = rsp_commit_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            dts_pkg::CSR_MIN_YEAR: min_year_in = csr_data;
            dts_pkg::CSR_MAX_YEAR: max_year_in = csr_data;
            default:               min_year_in = min_year_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in  = dts_pkg::mode_type'(req_tuser);
               data_in  = req_tdata[41:0];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            commit_in = 1'b0;
            wd_in     = 3'd0;
            yneg_in   = 1'b0;
            state_in  = S_FINISH;
            unique case (mode_ff)
               dts_pkg::MODE_TURN: begin
                  if (det != 6'sd0) begin
                     state_in = S_DIV_A;
                     acc_in   = acc_base + det_ext;
                     if (field_ff == dts_pkg::FLD_YEAR) begin
                        year_in = yr_clamped;
                        yop_in  = yr_clamped;
                     end else begin
                        yop_in  = year_ff;
                     end
                  end
               end
               dts_pkg::MODE_NEXT: begin
                  unique case (field_ff)
                     dts_pkg::FLD_YEAR:   field_in = dts_pkg::FLD_MONTH;
                     dts_pkg::FLD_MONTH:  field_in = dts_pkg::FLD_DAY;
                     dts_pkg::FLD_DAY:    field_in = dts_pkg::FLD_HOUR;
                     dts_pkg::FLD_HOUR:   field_in = dts_pkg::FLD_MINUTE;
                     default:             field_in = dts_pkg::FLD_YEAR;
                  endcase
               end
               dts_pkg::MODE_SAVE: begin
                  commit_in = 1'b1;
                  state_in  = S_DIV_A;
                  // January and February count as months of the previous year.
                  if (month_ff < 4'd3) begin
                     yop_in  = (year_ff == 12'd0) ? 12'd0 : (year_ff - 12'd1);
                     yneg_in = (year_ff == 12'd0);
                  end else begin
                     yop_in  = year_ff;
                  end
               end
               default: begin
                  if (load_good) begin
                     year_in   = clk_year;
                     month_in  = clk_month + 4'd1;
                     day_in    = ((clk_day >= 6'd1) && (clk_day <= 6'd31)) ? clk_day[4:0] : 5'd1;
                     hour_in   = (clk_hour <= 6'd23) ? clk_hour[4:0] : 5'd0;
                     minute_in = (clk_minute <= 7'd59) ? clk_minute[5:0] : 6'd0;
                  end
               end
            endcase
         end
         S_DIV_A: begin
            state_in = S_DIV_B;
         end
         S_DIV_B: begin
            q100_in  = q100_now;
            r25_in   = (10'(q100_now * 10'd25) == yop_ff[11:2]);
            state_in = S_DIV_C;
         end
         S_DIV_C: begin
            q400_in = q400_now;
            leap_in = leap_now;
            case (field_ff)
               dts_pkg::FLD_MONTH: mod_in = dts_pkg::MONTHS_PER_YEAR;
               dts_pkg::FLD_DAY:   mod_in = {1'b0, dim_now};
               dts_pkg::FLD_HOUR:  mod_in = dts_pkg::HOURS_PER_DAY;
               default:            mod_in = dts_pkg::MINUTES_PER_HOUR;
            endcase
            if (mode_ff == dts_pkg::MODE_SAVE) begin
               state_in = S_WD_SUM;
            end else if (field_ff == dts_pkg::FLD_YEAR) begin
               state_in = S_CLAMP;
            end else begin
               state_in = S_WRAP;
            end
         end
         S_WRAP: begin
            if (acc_low || acc_high) begin
               acc_in = wrap_sum;
            end else begin
               state_in = S_CLAMP;
               case (field_ff)
                  dts_pkg::FLD_MONTH: month_in  = acc_ff[3:0] + 4'd1;
                  dts_pkg::FLD_DAY:   day_in    = acc_ff[4:0] + 5'd1;
                  dts_pkg::FLD_HOUR:  hour_in   = acc_ff[4:0];
                  default:            minute_in = acc_ff[5:0];
               endcase
            end
         end
         S_CLAMP: begin
            if (day_ff > dts_pkg::days_in_month(month_ff, leap_ff)) begin
               day_in = dts_pkg::days_in_month(month_ff, leap_ff);
            end
            state_in = S_FINISH;
         end
         S_WD_SUM: begin
            // y + y/4 - y/100 + y/400 + offset + day, with y = -1 folded into yneg.
            sum_in = {1'b0, yop_ff} + {3'b000, yop_ff[11:2]} - {7'd0, q100_ff}
                     + {9'd0, q400_ff} + {10'd0, dts_pkg::month_offset(month_ff)}
                     + {8'd0, day_ff} - {12'd0, yneg_ff};
            state_in = S_WD_MUL;
         end
         S_WD_MUL: begin
            state_in = S_WD_FIN;
         end
         S_WD_FIN: begin
            wd_in    = wd_full[2:0];
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_commit_in = commit_ff;
               rsp_data_in   = {2'b00, wd_ff, field_ff, minute_ff, hour_ff, day_ff,
                                month_ff, year_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         min_year_ff   <= dts_pkg::MIN_YEAR_RESET;
         max_year_ff   <= dts_pkg::MAX_YEAR_RESET;
         year_ff       <= dts_pkg::YEAR_RESET;
         month_ff      <= 4'd1;
         day_ff        <= 5'd1;
         hour_ff       <= 5'd0;
         minute_ff     <= 6'd0;
         field_ff      <= dts_pkg::FLD_YEAR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         min_year_ff   <= min_year_in;
         max_year_ff   <= max_year_in;
         year_ff       <= year_in;
         month_ff      <= month_in;
         day_ff        <= day_in;
         hour_ff       <= hour_in;
         minute_ff     <= minute_in;
         field_ff      <= field_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      data_ff       <= data_in;
      yop_ff        <= yop_in;
      yneg_ff       <= yneg_in;
      acc_ff        <= acc_in;
      mod_ff        <= mod_in;
      prod_ff       <= prod_in;
      q100_ff       <= q100_in;
      q400_ff       <= q400_in;
      r25_ff        <= r25_in;
      leap_ff       <= leap_in;
      sum_ff        <= sum_in;
      wd_ff         <= wd_in;
      commit_ff     <= commit_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_commit_ff <= rsp_commit_in;
   end

endmodule

// ===== sv/dts_checker.sv =====
module dts_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [dts_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [1:0]                          req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [dts_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                rsp_tuser,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [11:0]                         csr_data
);

   // A stalled result holds its data and its commit flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Each field of a result but the year lies in its range (the day is checked against 1 only).
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:12] >= 4'd1) && (rsp_tdata[15:12] <= 4'd12)
                     && (rsp_tdata[20:16] >= 5'd1) && (rsp_tdata[25:21] <= 5'd23)
                     && (rsp_tdata[31:26] <= 6'd59) && (rsp_tdata[34:32] <= 3'd4)
                     && (rsp_tdata[37:35] <= 3'd6))
      else $error("result field out of range");

   // Only a save carries a weekday.
   a_wd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[37:35] == 3'd0)
      else $error("weekday set without commit");

   // The block works on one item at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind date_time_setter dts_checker u_dts_checker (.*);
